// ===== hw/rtl/mlpt_pkg.sv =====
// Shared types, constants and fixed-point helpers for the MLP trainer core.
// No dependencies; imported by the core, lane and merge modules of the block.
package mlpt_pkg;

	localparam int DEF_VOCAB_SIZE  = 64;
	localparam int DEF_HIDDEN_SIZE = 8;
	localparam int DEF_CLASS_COUNT = 16;

	localparam logic [1:0] CMD_INFER = 2'd0;
	localparam logic [1:0] CMD_TRAIN = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD     = 2'd1;
	localparam logic [1:0] CFG_ACTIVE        = 2'd2;

	localparam logic [15:0] RST_LEARNING_RATE = 16'd6554;
	localparam logic [15:0] RST_THRESHOLD     = 16'd32768;
	localparam logic [4:0]  RST_ACTIVE        = 5'd16;

	// round(65536 * sigmoid(k/2)), k = 0..16
	localparam logic [16:0] SIG_TAB [0:16] = '{
		17'd32768, 17'd40793, 17'd47911, 17'd53581, 17'd57724, 17'd60565,
		17'd62428, 17'd63615, 17'd64357, 17'd64816, 17'd65097, 17'd65269,
		17'd65374, 17'd65438, 17'd65476, 17'd65500, 17'd65514
	};

	typedef struct packed {
		logic [1:0]         cmd;
		logic [63:0]        bag_bits;
		logic [3:0]         target_class;
		logic [9:0]         weight_address;
		logic signed [15:0] weight_value;
	} item_t;

	typedef struct packed {
		logic [3:0]  class_index;
		logic [15:0] score;
		logic [3:0]  winner_class;
		logic        confident;
		logic        last;
	} result_t;

	// sequencer -> hidden lanes
	typedef struct packed {
		logic               clr_h;
		logic               clr_o;
		logic [5:0]         clr_addr;
		logic               host_hw;
		logic               host_hb;
		logic               host_ow;
		logic [4:0]         host_lane;
		logic [5:0]         host_j;
		logic [3:0]         host_k;
		logic signed [15:0] host_val;
		logic [5:0]         j;
		logic [3:0]         k;
		logic               acc_init;
		logic               acc_en;
		logic               h_sig;
		logic               o_mul;
		logic               b_clr;
		logic               b_upd;
		logic               b_acc;
		logic [3:0]         k_s1;
		logic signed [17:0] dout;
		logic signed [33:0] lrd;
		logic               d_a;
		logic               d_b;
		logic               d_c;
		logic [15:0]        lr;
		logic               u_wr;
		logic [5:0]         j_s1;
	} lane_ctl_t;

	// sequencer -> class-side merge stage
	typedef struct packed {
		logic               sum_en;
		logic               act_en;
		logic [3:0]         k_act;
		logic               host_ob;
		logic [3:0]         host_k;
		logic signed [15:0] host_val;
		logic [3:0]         rd_k;
		logic [3:0]         bk;
		logic               d_ph0;
		logic               d_ph1;
		logic               d_ph2;
		logic               t_on;
		logic               k_on;
		logic [15:0]        lr;
	} merge_ctl_t;

	function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -48'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// Q.12 argument to Q0.16 sigmoid, table with linear interpolation
	function automatic logic [15:0] sigm(input logic signed [23:0] x);
		logic [23:0] m;
		logic [4:0]  i;
		logic [10:0] f;
		logic [16:0] t0;
		logic [16:0] t1;
		logic [27:0] p;
		logic [16:0] s;
		m = x[23] ? 24'(-x) : 24'(x);
		i = {1'b0, m[14:11]};
		f = m[10:0];
		t0 = SIG_TAB[i];
		t1 = SIG_TAB[i + 5'd1];
		p = 28'(t1 - t0) * 28'(f) + 28'd1024;
		if (m >= 24'd32768) begin
			s = SIG_TAB[16];
		end else begin
			s = t0 + 17'(p >> 11);
		end
		if (x[23]) begin
			s = 17'd65536 - s;
		end
		if (s > 17'd65535) begin
			s = 17'd65535;
		end
		return s[15:0];
	endfunction

	// s * (1 - s) in Q0.16, rounded
	function automatic logic [15:0] sderiv(input logic [15:0] s);
		logic [32:0] p;
		p = 33'(s) * (33'd65536 - 33'(s)) + 33'd32768;
		return p[31:16];
	endfunction

endpackage

// ===== hw/rtl/mlp_sigmoid_backprop_trainer_core.sv =====
// Infer: the first score follows the hidden and class weight walks, then
// one score word per cycle for the active classes.
// Train: forward walks, output deltas, back-propagation and weight updates. Write: busy stays low.
// One command at a time; results leave on strobe, the receiver cannot stall.
// Reset: async, active low; a clearing pass zeroes the lane weight RAMs before
// the first command is taken.
module mlp_sigmoid_backprop_trainer_core #(
	parameter int VOCAB_SIZE  = mlpt_pkg::DEF_VOCAB_SIZE,
	parameter int HIDDEN_SIZE = mlpt_pkg::DEF_HIDDEN_SIZE,
	parameter int CLASS_COUNT = mlpt_pkg::DEF_CLASS_COUNT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mlpt_pkg::item_t   item,
	output logic              strobe,
	output mlpt_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import mlpt_pkg::*;

	localparam int VAW      = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
	localparam int MAXD     = (VOCAB_SIZE > CLASS_COUNT) ? VOCAB_SIZE : CLASS_COUNT;
	localparam int HB_BASE  = HIDDEN_SIZE * VOCAB_SIZE;
	localparam int OW_BASE  = HB_BASE + HIDDEN_SIZE;
	localparam int OB_BASE  = OW_BASE + CLASS_COUNT * HIDDEN_SIZE;
	localparam int STORE_END = OB_BASE + CLASS_COUNT;

	// Sequencer phases. Each weight walk issues one RAM read per cycle and then
	// drains the registered read and the products.
	typedef enum logic [11:0] {
		S_CLEAR = 12'b0000_0000_0001,  // zero the lane RAMs after reset
		S_IDLE  = 12'b0000_0000_0010,
		S_HRUN  = 12'b0000_0000_0100,  // hidden sums, one vocab word a cycle
		S_HSIG  = 12'b0000_0000_1000,  // hidden sigmoid in every lane
		S_ORUN  = 12'b0000_0001_0000,  // class sums, one class a cycle
		S_EMIT  = 12'b0000_0010_0000,  // score words out
		S_DOUT  = 12'b0000_0100_0000,  // output deltas, three steps a class
		S_BACK  = 12'b0000_1000_0000,  // back-prop sum and output weight update
		S_HDA   = 12'b0001_0000_0000,  // hidden derivative
		S_HDB   = 12'b0010_0000_0000,  // delta times derivative
		S_HDC   = 12'b0100_0000_0000,  // step size, hidden bias update
		S_HUPD  = 12'b1000_0000_0000   // hidden weight update of present words
	} state_t;

	state_t      state_q;
	logic [7:0]  cnt_q;
	logic [1:0]  ph_q;
	logic [VOCAB_SIZE-1:0] bag_q;
	logic [3:0]  target_q;
	logic        train_q;
	logic [15:0] lr_q;
	logic [15:0] thr_q;
	logic [4:0]  act_q;

	logic        v_s1, v_s2, v_s3;
	logic [3:0]  k_s1, k_s2, k_s3;
	logic [5:0]  j_s1;
	logic        bit_s1;

	logic [3:0]  best_idx_q;
	logic [15:0] best_sc_q;
	result_t     result_q;
	logic        strobe_q;

	lane_ctl_t   lctl;
	merge_ctl_t  mctl;
	logic [HIDDEN_SIZE-1:0][32:0] lane_prod;
	logic [15:0] score_rd;
	logic signed [17:0] dout_rd;
	logic signed [33:0] lrd_rd;

	logic        take;
	logic [4:0]  act_n;
	logic        iss;
	logic        iss_h;

	// host write decode
	logic        dec_hw, dec_hb, dec_ow, dec_ob;
	logic [4:0]  dec_lane;
	logic [5:0]  dec_j;
	logic [3:0]  dec_k;

	assign busy = (state_q != S_IDLE);
	assign take = start && !busy;

	// effective number of active classes
	always_comb begin
		if (act_q == 5'd0) begin
			act_n = 5'd1;
		end else if (act_q > 5'(CLASS_COUNT)) begin
			act_n = 5'(CLASS_COUNT);
		end else begin
			act_n = act_q;
		end
	end

	// flat address -> store, lane and local index; ranges compared in parallel
	always_comb begin
		int a;
		a = int'(item.weight_address);
		dec_hw = 1'b0;
		dec_hb = 1'b0;
		dec_ow = 1'b0;
		dec_ob = 1'b0;
		dec_lane = '0;
		dec_j = '0;
		dec_k = '0;
		if (a < HB_BASE) begin
			dec_hw = 1'b1;
			for (int i = 0; i < HIDDEN_SIZE; i++) begin
				if (a >= i * VOCAB_SIZE && a < (i + 1) * VOCAB_SIZE) begin
					dec_lane = 5'(i);
					dec_j = 6'(a - i * VOCAB_SIZE);
				end
			end
		end else if (a < OW_BASE) begin
			dec_hb = 1'b1;
			dec_lane = 5'(a - HB_BASE);
		end else if (a < OB_BASE) begin
			dec_ow = 1'b1;
			for (int k = 0; k < CLASS_COUNT; k++) begin
				if (a >= OW_BASE + k * HIDDEN_SIZE && a < OW_BASE + (k + 1) * HIDDEN_SIZE) begin
					dec_k = 4'(k);
					dec_lane = 5'(a - OW_BASE - k * HIDDEN_SIZE);
				end
			end
		end else if (a < STORE_END) begin
			dec_ob = 1'b1;
			dec_k = 4'(a - OB_BASE);
		end
	end

	assign iss_h = (state_q == S_HRUN || state_q == S_HUPD) && (cnt_q < 8'(VOCAB_SIZE));
	assign iss = iss_h
		|| ((state_q == S_ORUN || state_q == S_BACK) && (cnt_q < 8'(CLASS_COUNT)));

	// lane control
	always_comb begin
		logic wr;
		wr = take && (item.cmd == CMD_WRITE);
		lctl = '0;
		lctl.clr_h     = (state_q == S_CLEAR) && (cnt_q < 8'(VOCAB_SIZE));
		lctl.clr_o     = (state_q == S_CLEAR) && (cnt_q < 8'(CLASS_COUNT));
		lctl.clr_addr  = cnt_q[5:0];
		lctl.host_hw   = wr && dec_hw;
		lctl.host_hb   = wr && dec_hb;
		lctl.host_ow   = wr && dec_ow;
		lctl.host_lane = dec_lane;
		lctl.host_j    = dec_j;
		lctl.host_k    = dec_k;
		lctl.host_val  = item.weight_value;
		lctl.j         = cnt_q[5:0];
		lctl.k         = cnt_q[3:0];
		lctl.acc_init  = take && (item.cmd == CMD_INFER || item.cmd == CMD_TRAIN);
		lctl.acc_en    = (state_q == S_HRUN) && v_s1 && bit_s1;
		lctl.h_sig     = (state_q == S_HSIG);
		lctl.o_mul     = (state_q == S_ORUN) && v_s1;
		lctl.b_clr     = (state_q == S_DOUT);
		lctl.b_upd     = (state_q == S_BACK) && v_s1;
		lctl.b_acc     = (state_q == S_BACK) && v_s2;
		lctl.k_s1      = k_s1;
		lctl.dout      = dout_rd;
		lctl.lrd       = lrd_rd;
		lctl.d_a       = (state_q == S_HDA);
		lctl.d_b       = (state_q == S_HDB);
		lctl.d_c       = (state_q == S_HDC);
		lctl.lr        = lr_q;
		lctl.u_wr      = (state_q == S_HUPD) && v_s1 && bit_s1;
		lctl.j_s1      = j_s1;
	end

	// merge-stage control
	always_comb begin
		mctl = '0;
		mctl.sum_en   = (state_q == S_ORUN) && v_s2;
		mctl.act_en   = (state_q == S_ORUN) && v_s3;
		mctl.k_act    = k_s3;
		mctl.host_ob  = take && (item.cmd == CMD_WRITE) && dec_ob;
		mctl.host_k   = dec_k;
		mctl.host_val = item.weight_value;
		mctl.rd_k     = cnt_q[3:0];
		mctl.bk       = k_s1;
		mctl.d_ph0    = (state_q == S_DOUT) && (ph_q == 2'd0);
		mctl.d_ph1    = (state_q == S_DOUT) && (ph_q == 2'd1);
		mctl.d_ph2    = (state_q == S_DOUT) && (ph_q == 2'd2);
		mctl.t_on     = (cnt_q[3:0] == target_q);
		mctl.k_on     = (cnt_q < 8'(act_n));
		mctl.lr       = lr_q;
	end

	for (genvar g = 0; g < HIDDEN_SIZE; g++) begin : g_lane
		mlpt_lane #(
			.VOCAB_SIZE (VOCAB_SIZE),
			.CLASS_COUNT(CLASS_COUNT),
			.LANE_IDX   (g)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (lctl),
			.prod  (lane_prod[g])
		);
	end

	mlpt_merge #(
		.HIDDEN_SIZE(HIDDEN_SIZE),
		.CLASS_COUNT(CLASS_COUNT)
	) u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mctl),
		.prod  (lane_prod),
		.score (score_rd),
		.dout  (dout_rd),
		.lrd   (lrd_rd)
	);

	// configuration registers, written any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= RST_LEARNING_RATE;
			thr_q <= RST_THRESHOLD;
			act_q <= RST_ACTIVE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEARNING_RATE: lr_q  <= cfg_data;
				CFG_THRESHOLD:     thr_q <= cfg_data;
				CFG_ACTIVE:        act_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			ph_q    <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= iss;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == 8'(MAXD - 1)) begin
						state_q <= S_IDLE;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					ph_q <= '0;
					if (take && (item.cmd == CMD_INFER || item.cmd == CMD_TRAIN)) begin
						state_q <= S_HRUN;
					end
				end
				S_HRUN: begin
					if (cnt_q == 8'(VOCAB_SIZE)) begin
						state_q <= S_HSIG;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_HSIG: state_q <= S_ORUN;
				S_ORUN: begin
					if (cnt_q == 8'(CLASS_COUNT + 2)) begin
						state_q <= train_q ? S_DOUT : S_EMIT;
						cnt_q <= '0;
						ph_q <= '0;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_EMIT: begin
					if (cnt_q == 8'(act_n - 5'd1)) begin
						state_q <= S_IDLE;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_DOUT: begin
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (cnt_q == 8'(CLASS_COUNT - 1)) begin
							state_q <= S_BACK;
							cnt_q <= '0;
						end else begin
							cnt_q <= cnt_q + 8'd1;
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				S_BACK: begin
					if (cnt_q == 8'(CLASS_COUNT + 1)) begin
						state_q <= S_HDA;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_HDA: state_q <= S_HDB;
				S_HDB: state_q <= S_HDC;
				S_HDC: state_q <= S_HUPD;
				S_HUPD: begin
					if (cnt_q == 8'(VOCAB_SIZE)) begin
						state_q <= S_IDLE;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					cnt_q <= '0;
				end
			endcase
		end
	end

	// command capture and read pipeline tags
	always_ff @(posedge clk) begin
		if (take) begin
			bag_q    <= item.bag_bits[VOCAB_SIZE-1:0];
			target_q <= item.target_class;
			train_q  <= (item.cmd == CMD_TRAIN);
		end
		k_s1   <= cnt_q[3:0];
		k_s2   <= k_s1;
		k_s3   <= k_s2;
		j_s1   <= cnt_q[5:0];
		bit_s1 <= iss_h ? bag_q[cnt_q[VAW-1:0]] : 1'b0;
	end

	// score words: running argmax, lowest index wins ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == S_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		logic        first;
		logic        lst;
		logic [3:0]  nb_idx;
		logic [15:0] nb_sc;
		first = (cnt_q == 8'd0);
		lst = (cnt_q == 8'(act_n - 5'd1));
		if (first || score_rd > best_sc_q) begin
			nb_idx = cnt_q[3:0];
			nb_sc = score_rd;
		end else begin
			nb_idx = best_idx_q;
			nb_sc = best_sc_q;
		end
		if (state_q == S_EMIT) begin
			best_idx_q <= nb_idx;
			best_sc_q  <= nb_sc;
			result_q.class_index  <= cnt_q[3:0];
			result_q.score        <= score_rd;
			result_q.winner_class <= lst ? nb_idx : 4'd0;
			result_q.confident    <= lst && (nb_sc > thr_q);
			result_q.last         <= lst;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// a score word only follows an emission cycle
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == S_EMIT))
		else $error("score word outside emission");

	// score words of one inference are back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !result_q.last |=> strobe_q)
		else $error("gap inside score burst");

	// the winner is never a class not yet reported
	a_winner: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.last |-> result_q.winner_class <= result_q.class_index)
		else $error("winner beyond last class");

	// no command taken while the RAMs are being cleared
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> busy && !strobe_q)
		else $error("activity during clearing pass");
endmodule

// ===== hw/rtl/mlpt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mlpt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/mlpt_lane.sv =====
// One hidden neuron lane: its input weights, its column of output weights,
// bias, activation and back-propagated delta. Uses mlpt_pkg and mlpt_ram.
module mlpt_lane #(
	parameter int VOCAB_SIZE  = mlpt_pkg::DEF_VOCAB_SIZE,
	parameter int CLASS_COUNT = mlpt_pkg::DEF_CLASS_COUNT,
	parameter int LANE_IDX    = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mlpt_pkg::lane_ctl_t ctl,
	output logic [32:0]         prod
);
	import mlpt_pkg::*;

	localparam int VAW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
	localparam int CAW = $clog2(CLASS_COUNT);

	logic               hw_we;
	logic [VAW-1:0]     hw_waddr;
	logic [15:0]        hw_wdata;
	logic [15:0]        hw_rdata;
	logic               ow_we;
	logic [CAW-1:0]     ow_waddr;
	logic [15:0]        ow_wdata;
	logic [15:0]        ow_rdata;
	logic               sel;

	logic signed [15:0] hb_q;
	logic signed [23:0] acc_q;
	logic [15:0]        h_q;
	logic signed [32:0] prod_q;
	logic signed [33:0] bprod_q;
	logic signed [39:0] bacc_q;
	logic [15:0]        dh_q;
	logic signed [44:0] t_q;
	logic signed [25:0] inc_q;

	logic signed [15:0] ow_new;
	logic signed [15:0] hw_new;
	logic signed [25:0] inc_d;

	assign sel = (ctl.host_lane == 5'(LANE_IDX));

	always_comb begin
		logic signed [50:0] p;
		logic signed [50:0] r;
		p = ctl.lrd * $signed({1'b0, h_q});
		r = (p + (51'sd1 <<< 35)) >>> 36;
		ow_new = sat16(48'($signed(ow_rdata)) + 48'(r));
		hw_new = sat16(48'($signed(hw_rdata)) + 48'(inc_q));
	end

	always_comb begin
		logic signed [28:0] r16;
		logic signed [45:0] m;
		logic signed [45:0] r20;
		r16 = 29'((t_q + (45'sd1 <<< 15)) >>> 16);
		m = $signed({1'b0, ctl.lr}) * r16;
		r20 = (m + (46'sd1 <<< 19)) >>> 20;
		inc_d = r20[25:0];
	end

	always_comb begin
		hw_we = 1'b0;
		hw_waddr = ctl.j_s1[VAW-1:0];
		hw_wdata = hw_new;
		if (ctl.clr_h) begin
			hw_we = 1'b1;
			hw_waddr = ctl.clr_addr[VAW-1:0];
			hw_wdata = '0;
		end else if (ctl.host_hw && sel) begin
			hw_we = 1'b1;
			hw_waddr = ctl.host_j[VAW-1:0];
			hw_wdata = ctl.host_val;
		end else if (ctl.u_wr) begin
			hw_we = 1'b1;
		end
	end

	always_comb begin
		ow_we = 1'b0;
		ow_waddr = ctl.k_s1[CAW-1:0];
		ow_wdata = ow_new;
		if (ctl.clr_o) begin
			ow_we = 1'b1;
			ow_waddr = ctl.clr_addr[CAW-1:0];
			ow_wdata = '0;
		end else if (ctl.host_ow && sel) begin
			ow_we = 1'b1;
			ow_waddr = ctl.host_k[CAW-1:0];
			ow_wdata = ctl.host_val;
		end else if (ctl.b_upd) begin
			ow_we = 1'b1;
		end
	end

	mlpt_ram #(.WIDTH(16), .DEPTH(VOCAB_SIZE)) u_hw_ram (
		.clk  (clk),
		.we   (hw_we),
		.waddr(hw_waddr),
		.wdata(hw_wdata),
		.raddr(ctl.j[VAW-1:0]),
		.rdata(hw_rdata)
	);

	mlpt_ram #(.WIDTH(16), .DEPTH(CLASS_COUNT)) u_ow_ram (
		.clk  (clk),
		.we   (ow_we),
		.waddr(ow_waddr),
		.wdata(ow_wdata),
		.raddr(ctl.k[CAW-1:0]),
		.rdata(ow_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_q <= '0;
		end else if (ctl.host_hb && sel) begin
			hb_q <= ctl.host_val;
		end else if (ctl.d_c) begin
			hb_q <= sat16(48'(hb_q) + 48'(inc_d));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_init) begin
			acc_q <= 24'(hb_q);
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + 24'($signed(hw_rdata));
		end
		if (ctl.h_sig) begin
			h_q <= sigm(acc_q);
		end
		if (ctl.o_mul) begin
			prod_q <= $signed({1'b0, h_q}) * $signed(ow_rdata);
		end
		if (ctl.b_upd) begin
			bprod_q <= ctl.dout * $signed(ow_rdata);
		end
		if (ctl.b_clr) begin
			bacc_q <= '0;
		end else if (ctl.b_acc) begin
			bacc_q <= bacc_q + 40'(bprod_q);
		end
		if (ctl.d_a) begin
			dh_q <= sderiv(h_q);
		end
		if (ctl.d_b) begin
			t_q <= 28'((bacc_q + (40'sd1 <<< 11)) >>> 12) * $signed({1'b0, dh_q});
		end
		if (ctl.d_c) begin
			inc_q <= inc_d;
		end
	end

	assign prod = prod_q;
endmodule

// ===== hw/rtl/mlpt_merge.sv =====
// Class-side merge stage: sums lane products, output sigmoid, output biases,
// output deltas. Uses mlpt_pkg.
module mlpt_merge #(
	parameter int HIDDEN_SIZE = mlpt_pkg::DEF_HIDDEN_SIZE,
	parameter int CLASS_COUNT = mlpt_pkg::DEF_CLASS_COUNT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mlpt_pkg::merge_ctl_t                ctl,
	input  logic [HIDDEN_SIZE-1:0][32:0]        prod,
	output logic [15:0]                         score,
	output logic signed [17:0]                  dout,
	output logic signed [33:0]                  lrd
);
	import mlpt_pkg::*;

	localparam int CAW = $clog2(CLASS_COUNT);

	logic signed [15:0] ob_q   [CLASS_COUNT];
	logic [15:0]        oact_q [CLASS_COUNT];
	logic signed [17:0] dout_q [CLASS_COUNT];
	logic signed [33:0] lrd_q  [CLASS_COUNT];
	logic signed [37:0] sum_q;
	logic [15:0]        dv_q;
	logic signed [17:0] dcur_q;

	logic signed [37:0] sum_d;
	logic signed [23:0] arg;
	logic signed [17:0] dout_d;
	logic signed [34:0] lp;
	logic signed [15:0] ob_new;

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < HIDDEN_SIZE; i++) begin
			sum_d = sum_d + {{5{prod[i][32]}}, prod[i]};
		end
	end

	always_comb begin
		logic signed [37:0] r;
		r = (sum_q + (38'sd1 <<< 15)) >>> 16;
		arg = r[23:0] + 24'(ob_q[ctl.k_act[CAW-1:0]]);
	end

	always_comb begin
		logic signed [17:0] err;
		logic signed [34:0] p;
		logic signed [34:0] r;
		err = (ctl.t_on ? 18'sd65536 : 18'sd0) - $signed({2'b0, oact_q[ctl.rd_k[CAW-1:0]]});
		p = err * $signed({1'b0, dv_q});
		r = (p + (35'sd1 <<< 15)) >>> 16;
		dout_d = ctl.k_on ? r[17:0] : 18'sd0;
	end

	always_comb begin
		logic signed [34:0] r;
		lp = $signed({1'b0, ctl.lr}) * dcur_q;
		r = (lp + (35'sd1 <<< 19)) >>> 20;
		ob_new = sat16(48'(ob_q[ctl.rd_k[CAW-1:0]]) + 48'(r));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				ob_q[i] <= '0;
			end
		end else if (ctl.host_ob) begin
			ob_q[ctl.host_k[CAW-1:0]] <= ctl.host_val;
		end else if (ctl.d_ph2) begin
			ob_q[ctl.rd_k[CAW-1:0]] <= ob_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			sum_q <= sum_d;
		end
		if (ctl.act_en) begin
			oact_q[ctl.k_act[CAW-1:0]] <= sigm(arg);
		end
		if (ctl.d_ph0) begin
			dv_q <= sderiv(oact_q[ctl.rd_k[CAW-1:0]]);
		end
		if (ctl.d_ph1) begin
			dcur_q <= dout_d;
			dout_q[ctl.rd_k[CAW-1:0]] <= dout_d;
		end
		if (ctl.d_ph2) begin
			lrd_q[ctl.rd_k[CAW-1:0]] <= lp[33:0];
		end
	end

	assign score = oact_q[ctl.rd_k[CAW-1:0]];
	assign dout  = dout_q[ctl.bk[CAW-1:0]];
	assign lrd   = lrd_q[ctl.bk[CAW-1:0]];
endmodule

// ===== sim/mlpt_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the MLP trainer core: watches the command, config and score ports,
// keeps its own copy of weights and config, and checks every score word.
// Depends on mlpt_pkg for the item and result types and the sigmoid table.
module mlpt_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  mlpt_pkg::item_t   item,
	input  logic              strobe,
	input  mlpt_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                pending,
	output int                failures
);
	import mlpt_pkg::*;

	localparam int NV = DEF_VOCAB_SIZE;
	localparam int NH = DEF_HIDDEN_SIZE;
	localparam int NC = DEF_CLASS_COUNT;
	localparam int HB_AT = NH * NV;
	localparam int OW_AT = HB_AT + NH;
	localparam int OB_AT = OW_AT + NC * NH;
	localparam int END_AT = OB_AT + NC;

	shortint     w_hid [NH*NV];
	shortint     b_hid [NH];
	shortint     w_out [NC*NH];
	shortint     b_out [NC];
	longint      act_h [NH];
	longint      act_o [NC];
	logic [15:0] rate;
	logic [15:0] thresh;
	logic [4:0]  n_active;
	result_t     score_q [$];

	function automatic longint rnd_shift(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic shortint clamp16(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return shortint'(v);
	endfunction

	// Q.12 in, Q0.16 out
	function automatic longint squash(longint x);
		longint m, s, t0, t1;
		int    i;
		m = (x < 0) ? -x : x;
		if (m >= 32768) begin
			s = SIG_TAB[16];
		end else begin
			i = int'(m >> 11);
			t0 = SIG_TAB[i];
			t1 = SIG_TAB[i+1];
			s = t0 + (((t1 - t0) * (m & 2047) + 1024) >>> 11);
		end
		if (x < 0) s = 65536 - s;
		if (s > 65535) s = 65535;
		return s;
	endfunction

	function automatic longint slope(longint s);
		return (s * (65536 - s) + 32768) >> 16;
	endfunction

	function automatic int classes_in_use();
		if (n_active < 1) return 1;
		if (n_active > NC) return NC;
		return int'(n_active);
	endfunction

	task automatic forward_pass(logic [63:0] bag);
		longint acc;
		for (int i = 0; i < NH; i++) begin
			acc = b_hid[i];
			for (int j = 0; j < NV; j++)
				if (bag[j]) acc += w_hid[i*NV+j];
			act_h[i] = squash(acc);
		end
		for (int k = 0; k < NC; k++) begin
			acc = 0;
			for (int j = 0; j < NH; j++)
				acc += act_h[j] * longint'(w_out[k*NH+j]);
			act_o[k] = squash(rnd_shift(acc, 16) + b_out[k]);
		end
	endtask

	task automatic train_pass(logic [63:0] bag, logic [3:0] tgt);
		longint d_o [NC];
		longint d_h [NH];
		longint sum, inc, lr;
		int     a;
		lr = rate;
		a = classes_in_use();
		forward_pass(bag);
		for (int k = 0; k < a; k++)
			d_o[k] = rnd_shift((((k == tgt) ? 65536 : 0) - act_o[k]) * slope(act_o[k]), 16);
		for (int j = 0; j < NH; j++) begin
			sum = 0;
			for (int k = 0; k < a; k++)
				sum += d_o[k] * w_out[k*NH+j];
			d_h[j] = rnd_shift(rnd_shift(sum, 12) * slope(act_h[j]), 16);
		end
		for (int k = 0; k < a; k++) begin
			for (int j = 0; j < NH; j++) begin
				inc = rnd_shift(lr * d_o[k] * act_h[j], 36);
				w_out[k*NH+j] = clamp16(w_out[k*NH+j] + inc);
			end
			b_out[k] = clamp16(b_out[k] + rnd_shift(lr * d_o[k], 20));
		end
		for (int i = 0; i < NH; i++) begin
			inc = rnd_shift(lr * d_h[i], 20);
			for (int j = 0; j < NV; j++)
				if (bag[j]) w_hid[i*NV+j] = clamp16(w_hid[i*NV+j] + inc);
			b_hid[i] = clamp16(b_hid[i] + inc);
		end
	endtask

	task automatic infer_pass(logic [63:0] bag);
		int      a, win;
		result_t r;
		forward_pass(bag);
		a = classes_in_use();
		win = 0;
		for (int k = 1; k < a; k++)
			if (act_o[k] > act_o[win]) win = k;
		for (int k = 0; k < a; k++) begin
			r.class_index  = 4'(k);
			r.score        = 16'(act_o[k]);
			r.last         = (k == a - 1);
			r.winner_class = r.last ? 4'(win) : 4'd0;
			r.confident    = r.last && (act_o[win] > thresh);
			score_q = {score_q, r};
		end
	endtask

	task automatic load_word(logic [9:0] adr, shortint v);
		if (adr < HB_AT) w_hid[adr] = v;
		else if (adr < OW_AT) b_hid[adr - HB_AT] = v;
		else if (adr < OB_AT) w_out[adr - OW_AT] = v;
		else if (adr < END_AT) b_out[adr - OB_AT] = v;
	endtask

	initial begin
		foreach (w_hid[i]) w_hid[i] = 0;
		foreach (w_out[i]) w_out[i] = 0;
		foreach (b_hid[i]) b_hid[i] = 0;
		foreach (b_out[i]) b_out[i] = 0;
		rate = RST_LEARNING_RATE;
		thresh = RST_THRESHOLD;
		n_active = RST_ACTIVE;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_LEARNING_RATE: rate = cfg_data;
					CFG_THRESHOLD:     thresh = cfg_data;
					CFG_ACTIVE:        n_active = cfg_data[4:0];
					default: ;
				endcase
			end
			if (strobe) begin
				if (score_q.size() == 0) begin
					$error("unexpected score word: class %0d score %0d",
						result.class_index, result.score);
					failures++;
				end else begin
					result_t e;
					e = score_q.pop_front();
					if (result.class_index !== e.class_index) begin
						$error("class_index exp %0d got %0d", e.class_index, result.class_index);
						failures++;
					end
					if (result.score !== e.score) begin
						$error("score exp %0d got %0d", e.score, result.score);
						failures++;
					end
					if (result.winner_class !== e.winner_class) begin
						$error("winner_class exp %0d got %0d", e.winner_class,
							result.winner_class);
						failures++;
					end
					if (result.confident !== e.confident) begin
						$error("confident exp %0b got %0b", e.confident, result.confident);
						failures++;
					end
					if (result.last !== e.last) begin
						$error("last exp %0b got %0b", e.last, result.last);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				case (item.cmd)
					CMD_INFER: infer_pass(item.bag_bits);
					CMD_TRAIN: train_pass(item.bag_bits, item.target_class);
					CMD_WRITE: load_word(item.weight_address, item.weight_value);
					default: ;
				endcase
			end
		end
		pending = score_q.size();
	end

endmodule

// ===== sim/mlp_sigmoid_backprop_trainer_core_test.sv =====
`timescale 1ns / 100ps
// Top of the MLP trainer core bench: clock, reset, command and config stimulus.
// Depends on mlpt_pkg, the core and mlpt_checker, which does all the checking.
module mlp_sigmoid_backprop_trainer_core_test;
	import mlpt_pkg::*;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;
	logic    cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int      pending;
	int      failures;

	mlp_sigmoid_backprop_trainer_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mlpt_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pending(pending), .failures(failures)
	);

	// 12 ns period
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Hold start high and wait for the edge that takes the word; busy is read
	// right after the edge, so it is still the value the core saw.
	task automatic issue(item_t w);
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
	endtask

	// Sender gaps: mostly none or short, now and then long.
	task automatic idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r >= 50) begin
			start <= 1'b0;
			item <= item_t'({$urandom, $urandom, $urandom});
			repeat ((r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40))
				@(posedge clk);
		end
	endtask

	// Drain: all scores in and the core idle; train and write leave no word,
	// so give it a few edges to raise busy before trusting busy low.
	task automatic settle();
		start <= 1'b0;
		repeat (4) @(posedge clk);
		while (busy || pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t make_cmd(logic [1:0] c, logic [63:0] bag, logic [3:0] tgt,
		logic [9:0] adr, logic [15:0] val);
		item_t w;
		w.cmd = c;
		w.bag_bits = bag;
		w.target_class = tgt;
		w.weight_address = adr;
		w.weight_value = val;
		return w;
	endfunction

	// Bags of varied density so hidden sums span small and saturated ranges.
	function automatic logic [63:0] rand_bag();
		logic [63:0] b;
		b = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: b = b & {$urandom, $urandom} & {$urandom, $urandom};
			1: b = 64'd1 << $urandom_range(0, 63);
			default: ;
		endcase
		return b;
	endfunction

	function automatic item_t rand_cmd();
		int r;
		logic [9:0] adr;
		logic [15:0] val;
		r = $urandom_range(0, 99);
		adr = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(664, 1023))
			: 10'($urandom_range(0, 663));
		// small weights keep the net out of saturation most of the time
		val = ($urandom_range(0, 4) == 0) ? 16'($urandom)
			: 16'($signed($urandom_range(0, 8191)) - 4096);
		if (r < 30)
			return make_cmd(CMD_WRITE, rand_bag(), 4'($urandom), adr, val);
		if (r < 60)
			return make_cmd(CMD_TRAIN, rand_bag(), 4'($urandom), adr, val);
		if (r < 96)
			return make_cmd(CMD_INFER, rand_bag(), 4'($urandom), adr, val);
		return make_cmd(2'd3, rand_bag(), 4'($urandom), adr, val);
	endfunction

	initial begin
		logic [15:0] lr_set [5] = '{16'd0, 16'd65535, 16'd6554, 16'd40000, 16'd1000};
		logic [15:0] th_set [5] = '{16'd0, 16'd65535, 16'd32768, 16'd50000, 16'd20000};
		logic [4:0]  ac_set [5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7};

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: store edges, value extremes, out-of-range address
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd0, 16'h7FFF));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd511, 16'h8000));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd512, 16'h1000));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd519, 16'hF000));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd520, 16'h2000));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd647, 16'hE000));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd648, 16'h0800));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd663, 16'h7FFF));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd664, 16'h1234));
		issue(make_cmd(CMD_WRITE, '0, 4'd0, 10'd1023, 16'hFFFF));
		// all-zero and all-ones bags; ties among untouched classes
		issue(make_cmd(CMD_INFER, '0, 4'd0, 10'd0, 16'd0));
		issue(make_cmd(CMD_INFER, '1, 4'd15, 10'd1023, 16'hFFFF));
		issue(make_cmd(CMD_TRAIN, '1, 4'd0, 10'd0, 16'd0));
		issue(make_cmd(CMD_TRAIN, 64'h8000_0000_0000_0001, 4'd15, 10'd0, 16'd0));
		issue(make_cmd(2'd3, '1, 4'd3, 10'd0, 16'h7FFF));
		issue(make_cmd(CMD_INFER, 64'hAAAA_5555_F0F0_0F0F, 4'd0, 10'd0, 16'd0));
		settle();

		// Few classes: target beyond the active range trains toward all zero
		set_reg(CFG_ACTIVE, 16'd3);
		set_reg(CFG_THRESHOLD, 16'd0);
		issue(make_cmd(CMD_TRAIN, '1, 4'd9, 10'd0, 16'd0));
		issue(make_cmd(CMD_INFER, '1, 4'd0, 10'd0, 16'd0));
		settle();
		set_reg(CFG_ACTIVE, 16'd0);
		set_reg(CFG_LEARNING_RATE, 16'd65535);
		issue(make_cmd(CMD_TRAIN, 64'hFF, 4'd0, 10'd0, 16'd0));
		issue(make_cmd(CMD_INFER, 64'hFF, 4'd0, 10'd0, 16'd0));
		settle();

		// Random phases, each under its own register setting
		for (int p = 0; p < 5; p++) begin
			set_reg(CFG_LEARNING_RATE, lr_set[p]);
			set_reg(CFG_THRESHOLD, th_set[p]);
			set_reg(CFG_ACTIVE, 16'(ac_set[p]));
			for (int n = 0; n < 78; n++) begin
				issue(rand_cmd());
				if ($urandom_range(0, 3) != 0) idle_gap();
			end
			settle();
		end

		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run
	initial begin
		#30ms;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mlpt_pkg.sv
hw/rtl/mlpt_ram.sv
hw/rtl/mlpt_lane.sv
hw/rtl/mlpt_merge.sv
hw/rtl/mlp_sigmoid_backprop_trainer_core.sv
sim/mlpt_checker.sv
sim/mlp_sigmoid_backprop_trainer_core_test.sv
